@@ rtl/core/bsfd_pkg.sv @@
// Shared types, register codes, status codes and the CRC7 byte function of the deframer.
package bsfd_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        CFG_SYNC     = 2'd0,
        CFG_END      = 2'd1,
        CFG_ESCAPE   = 2'd2,
        CFG_FIRST_IF = 2'd3
    } cfg_index_t;

    // End-of-frame status codes.
    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_CRC      = 3'd1,
        STATUS_SHORT    = 3'd2,
        STATUS_RESTART  = 3'd3,
        STATUS_OVERFLOW = 3'd4
    } status_t;

    localparam logic [7:0] SYNC_RESET     = 8'd254;
    localparam logic [7:0] END_RESET      = 8'd255;
    localparam logic [7:0] ESCAPE_RESET   = 8'd253;
    localparam logic [3:0] FIRST_IF_RESET = 4'd0;

    // CRC7 polynomial 0x09, worked MSB-aligned in an 8-bit register.
    localparam logic [7:0] CRC_POLY_SHIFTED = 8'h12;

    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] end_value;
        logic [7:0] escape_value;
        logic [3:0] first_interface;
    } cfg_t;

    typedef struct packed {
        logic [1:0] channel;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [4:0] interface_id;
        logic [7:0] frame_byte;
        logic       last;
        status_t    status;
    } result_t;

    // One byte of CRC7: eight shift steps on an 8-bit value.
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = {1'b0, crc} ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY_SHIFTED;
            else
                c = {c[6:0], 1'b0};
        end
        return c[7:1];
    endfunction

endpackage

@@ rtl/core/bsfd_cfg_regs.sv @@
// Configuration register file of the deframer.
module bsfd_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [7:0]          wr_data,
    output bsfd_pkg::cfg_t      cfg
);

    bsfd_pkg::cfg_t cfg_reg;
    bsfd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (bsfd_pkg::cfg_index_t'(wr_index))
                bsfd_pkg::CFG_SYNC:     cfg_next.sync_value      = wr_data;
                bsfd_pkg::CFG_END:      cfg_next.end_value       = wr_data;
                bsfd_pkg::CFG_ESCAPE:   cfg_next.escape_value    = wr_data;
                bsfd_pkg::CFG_FIRST_IF: cfg_next.first_interface = wr_data[3:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value      <= bsfd_pkg::SYNC_RESET;
            cfg_reg.end_value       <= bsfd_pkg::END_RESET;
            cfg_reg.escape_value    <= bsfd_pkg::ESCAPE_RESET;
            cfg_reg.first_interface <= bsfd_pkg::FIRST_IF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/bsfd_deframer.sv @@
// Per-channel deframer context store and the single-pass byte step logic.
module bsfd_deframer #(
    parameter int CHANNELS  = 4,
    parameter int RAW_LIMIT = 256,
    parameter int FRAME_MAX = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bsfd_pkg::cfg_t      cfg,
    input  logic                step_en,
    input  bsfd_pkg::item_t     item,
    output logic                res_valid,
    output bsfd_pkg::result_t   res
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAW_W = $clog2(RAW_LIMIT);
    localparam int DEC_W = (FRAME_MAX > 1) ? $clog2(FRAME_MAX + 1) : 1;

    typedef struct packed {
        logic             in_frame;
        logic [6:0]       running_crc;
        logic [7:0]       held_raw;
        logic             held_valid;
        logic             escape_pending;
        logic [RAW_W-1:0] raw_count;
        logic [DEC_W-1:0] decoded_count;
    } ctx_t;

    ctx_t ctx_reg [CHANNELS];

    logic [CH_W-1:0] idx;
    logic            in_range;
    ctx_t            cur;
    ctx_t            nxt;
    logic            rx_sync;
    logic            rx_end;
    logic            overflow;
    logic            have_data;
    logic [7:0]      data;

    assign in_range = 32'(item.channel) < CHANNELS;
    assign idx      = CH_W'(item.channel);
    assign cur      = in_range ? ctx_reg[idx] : '0;
    assign rx_sync  = item.rx_byte == cfg.sync_value;
    assign rx_end   = item.rx_byte == cfg.end_value;
    assign overflow = cur.in_frame && (cur.raw_count >= RAW_W'(RAW_LIMIT - 1));

    always_comb
    begin
        nxt                = cur;
        res_valid          = 1'b0;
        res.interface_id   = 5'(cfg.first_interface) + 5'(item.channel);
        res.frame_byte     = '0;
        res.last           = 1'b0;
        res.status         = bsfd_pkg::STATUS_OK;
        have_data          = 1'b0;
        data               = '0;

        if (overflow)
        begin
            // Frame closes; the same byte is then seen by the hunter.
            res_valid    = 1'b1;
            res.last     = 1'b1;
            res.status   = bsfd_pkg::STATUS_OVERFLOW;
            nxt          = '0;
            nxt.in_frame = rx_sync;
        end
        else if (!cur.in_frame)
        begin
            if (rx_sync)
            begin
                nxt          = '0;
                nxt.in_frame = 1'b1;
            end
        end
        else if (rx_sync)
        begin
            res_valid    = 1'b1;
            res.last     = 1'b1;
            res.status   = bsfd_pkg::STATUS_RESTART;
            nxt          = '0;
            nxt.in_frame = 1'b1;
        end
        else if (rx_end)
        begin
            res_valid = 1'b1;
            res.last  = 1'b1;
            if (cur.raw_count < RAW_W'(2))
                res.status = bsfd_pkg::STATUS_SHORT;
            else if ({1'b0, cur.running_crc} == cur.held_raw)
                res.status = bsfd_pkg::STATUS_OK;
            else
                res.status = bsfd_pkg::STATUS_CRC;
            nxt = '0;
        end
        else
        begin
            if (cur.held_valid)
            begin
                nxt.running_crc = bsfd_pkg::crc7_byte(cur.running_crc, cur.held_raw);
                if (cur.escape_pending)
                begin
                    nxt.escape_pending = 1'b0;
                    data               = cur.held_raw + cfg.escape_value;
                    have_data          = 1'b1;
                end
                else if (cur.held_raw == cfg.escape_value)
                begin
                    nxt.escape_pending = 1'b1;
                end
                else
                begin
                    data      = cur.held_raw;
                    have_data = 1'b1;
                end
                if (have_data && (cur.decoded_count < DEC_W'(FRAME_MAX)))
                begin
                    nxt.decoded_count = cur.decoded_count + DEC_W'(1);
                    res_valid         = 1'b1;
                    res.frame_byte    = data;
                end
            end
            nxt.held_raw   = item.rx_byte;
            nxt.held_valid = 1'b1;
            nxt.raw_count  = cur.raw_count + RAW_W'(1);
        end

        if (!in_range)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                ctx_reg[i] <= '0;
            end
        end
        else if (step_en && in_range)
        begin
            ctx_reg[idx] <= nxt;
        end
    end

endmodule

@@ rtl/core/byte_stuffing_frame_decoder_core.sv @@
// Top level of the byte-stuffed serial deframer with per-channel CRC7 check.
//
//  Channel   Signals                                    Direction  Beat
//  item      item_valid, item_stall, item               in         one raw byte of a channel
//  result    result_valid, result_stall, result         out        one data byte or frame status
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  in         one register write
//
// Each accepted beat is held in the input register, where the channel's context
// is read, updated and written back in the same cycle; its result (if any) is
// registered into the output register, and one beat per cycle is sustained
// unless a result stalls. The context store is written at the end of the cycle
// that uses it, so beats for the same channel may follow each other directly.
// Reset clears every channel's context to hunting and restores the register
// defaults. A stalled result holds the input register, which then stalls the item
// channel; beats that give no result still wait behind it.
module byte_stuffing_frame_decoder_core #(
    parameter int CHANNELS  = 4,
    parameter int RAW_LIMIT = 256,
    parameter int FRAME_MAX = 64
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_stall,
    input  bsfd_pkg::item_t     item,

    output logic                result_valid,
    input  logic                result_stall,
    output bsfd_pkg::result_t   result,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    bsfd_pkg::cfg_t    cfg;

    // Input register.
    logic              in_valid_reg;
    logic              in_valid_next;
    bsfd_pkg::item_t   in_item_reg;

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    bsfd_pkg::result_t out_item_reg;

    logic              step_en;
    logic              step_res_valid;
    bsfd_pkg::result_t step_res;
    logic              out_blocked;

    // Register writes are always taken; the user must issue them only while the block is idle.
    assign cfg_ready = 1'b1;

    bsfd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The held beat may only be processed when its result has somewhere to go.
    assign out_blocked = out_valid_reg && result_stall;
    assign step_en     = in_valid_reg && !out_blocked;
    assign item_stall  = in_valid_reg && out_blocked;

    bsfd_deframer #(
        .CHANNELS  (CHANNELS),
        .RAW_LIMIT (RAW_LIMIT),
        .FRAME_MAX (FRAME_MAX)
    ) u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step_en   (step_en),
        .item      (in_item_reg),
        .res_valid (step_res_valid),
        .res       (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!item_stall)
        begin
            in_valid_next = item_valid;
        end

        out_valid_next = out_valid_reg;
        if (!out_blocked)
        begin
            out_valid_next = step_en && step_res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
        if (step_en && step_res_valid)
        begin
            out_item_reg <= step_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

@@ rtl/core/bsfd_checker.sv @@
// Port-level checks for the deframer top level, with the bind that attaches them.
module bsfd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input bsfd_pkg::result_t result
);

    // A stalled result beat stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // The item channel stalls only behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stall without result back-pressure");

    // Data beats carry a zero status; status beats carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.status == bsfd_pkg::STATUS_OK)
        else $error("data beat with non-zero status");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> result.frame_byte == 8'd0)
        else $error("status beat with non-zero byte");

endmodule

bind byte_stuffing_frame_decoder_core bsfd_checker u_bsfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the byte-stuffed deframer: directed frames, then random traffic.
`timescale 1ns / 1ps

module tb_top;

    // Sizes match the defaults of the core.
    localparam int CHANNELS  = 4;
    localparam int RAW_LIMIT = 256;
    localparam int FRAME_MAX = 64;

    // Cycles allowed after the last awaited result before the block is treated as idle.
    localparam int SETTLE_CYCLES = 4;
    // Length of the one long receiver hold-off that fills the pipeline.
    localparam int LONG_HOLD_CYCLES = 60;
    // Marks the slot in a planned frame where the correct check byte goes.
    localparam int CRC_SLOT = -1;

    // Register settings of the later phases; the last phase draws its own.
    localparam bsfd_pkg::cfg_t PHASE_CFG [3] = '{
        '{sync_value: 8'h00, end_value: 8'hFF, escape_value: 8'h7D, first_interface: 4'hF},
        '{sync_value: 8'hFF, end_value: 8'h00, escape_value: 8'h00, first_interface: 4'h1},
        '{sync_value: 8'h7E, end_value: 8'h7E, escape_value: 8'hFF, first_interface: 4'h8}
    };

    typedef enum {ROW_PREDICT, ROW_QUIET, ROW_STATUS, ROW_CRC} row_kind_t;

    typedef struct {
        logic [1:0]        channel;
        logic [7:0]        rx_byte;
        row_kind_t         kind;
        bsfd_pkg::status_t status;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    bsfd_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    bsfd_pkg::result_t result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [7:0]        cfg_data = '0;

    // Register copies held by the bench.
    logic [7:0] sync_val;
    logic [7:0] end_val;
    logic [7:0] esc_val;
    logic [3:0] first_if;

    // Per-channel deframer context as the bench expects it.
    logic        in_frame [CHANNELS];
    logic [6:0]  run_crc  [CHANNELS];
    logic [7:0]  held     [CHANNELS];
    logic        held_ok  [CHANNELS];
    logic        esc_pend [CHANNELS];
    int unsigned raw_cnt  [CHANNELS];
    int unsigned data_cnt [CHANNELS];

    bsfd_pkg::result_t due_beats [$];
    int                frame_plan [CHANNELS][$];
    stim_row_t         rows [$];
    int unsigned       mismatches = 0;
    int unsigned       burst_left = 0;
    bit                long_hold_wanted = 1'b0;
    bit                in_long_hold = 1'b0;

    byte_stuffing_frame_decoder_core #(
        .CHANNELS  (CHANNELS),
        .RAW_LIMIT (RAW_LIMIT),
        .FRAME_MAX (FRAME_MAX)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The check sequence: the 7-bit remainder is XORed into the low bits of the
    // byte and the whole 8-bit value is shifted through the polynomial 0x09,
    // carried one place to the left.
    function automatic logic [6:0] crc7_next(input logic [6:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = data ^ {1'b0, acc};
        repeat (8)
            r = r[7] ? ((r << 1) ^ 8'h12) : (r << 1);
        return r[7:1];
    endfunction

    function automatic logic [4:0] iface_of(input int unsigned ch);
        return 5'(first_if) + 5'(ch);
    endfunction

    function automatic bsfd_pkg::result_t status_beat(input int unsigned ch,
                                                      input bsfd_pkg::status_t st);
        bsfd_pkg::result_t r;
        r.interface_id = iface_of(ch);
        r.frame_byte   = '0;
        r.last         = 1'b1;
        r.status       = st;
        return r;
    endfunction

    // Wipes one channel's context; the channel is either left hunting or put
    // straight into a fresh frame.
    function automatic void clear_context(input int unsigned ch, input logic open);
        in_frame[ch] = open;
        run_crc[ch]  = '0;
        held[ch]     = '0;
        held_ok[ch]  = 1'b0;
        esc_pend[ch] = 1'b0;
        raw_cnt[ch]  = 0;
        data_cnt[ch] = 0;
    endfunction

    // Works out what one accepted item beat should produce and moves the
    // channel's context on. Returns 1 when a result beat is due.
    function automatic bit deframe_byte(input bsfd_pkg::item_t beat,
                                        output bsfd_pkg::result_t r);
        int unsigned       ch;
        logic [7:0]        b;
        logic [7:0]        h;
        logic [7:0]        data;
        bit                produced;
        bit                have;
        bsfd_pkg::status_t st;
        ch = int'(beat.channel);
        b = beat.rx_byte;
        produced = 1'b0;
        r = '0;
        // A frame that has run out of room is closed first; the byte itself is
        // then treated as if the channel were hunting.
        if (in_frame[ch] && raw_cnt[ch] + 1 >= RAW_LIMIT)
        begin
            r = status_beat(ch, bsfd_pkg::STATUS_OVERFLOW);
            clear_context(ch, 1'b0);
            produced = 1'b1;
        end
        if (!in_frame[ch])
        begin
            if (b == sync_val)
                clear_context(ch, 1'b1);
            return produced;
        end
        if (b == sync_val)
        begin
            r = status_beat(ch, bsfd_pkg::STATUS_RESTART);
            clear_context(ch, 1'b1);
            return 1'b1;
        end
        if (b == end_val)
        begin
            if (raw_cnt[ch] < 2)
                st = bsfd_pkg::STATUS_SHORT;
            else if ({1'b0, run_crc[ch]} == held[ch])
                st = bsfd_pkg::STATUS_OK;
            else
                st = bsfd_pkg::STATUS_CRC;
            r = status_beat(ch, st);
            clear_context(ch, 1'b0);
            return 1'b1;
        end
        // The byte held back from last time is now known not to be the check
        // byte, so it enters the CRC and may come out as data.
        if (held_ok[ch])
        begin
            h = held[ch];
            have = 1'b1;
            data = h;
            run_crc[ch] = crc7_next(run_crc[ch], h);
            if (esc_pend[ch])
            begin
                esc_pend[ch] = 1'b0;
                data = h + esc_val;
            end
            else if (h == esc_val)
            begin
                esc_pend[ch] = 1'b1;
                have = 1'b0;
            end
            if (have && data_cnt[ch] < FRAME_MAX)
            begin
                data_cnt[ch]++;
                r.interface_id = iface_of(ch);
                r.frame_byte   = data;
                r.last         = 1'b0;
                r.status       = bsfd_pkg::STATUS_OK;
                produced = 1'b1;
            end
        end
        held[ch] = b;
        held_ok[ch] = 1'b1;
        raw_cnt[ch]++;
        return produced;
    endfunction

    // The byte that makes the frame's check pass if sent now on this channel.
    function automatic logic [7:0] crc_byte_for(input int unsigned ch);
        return {1'b0, held_ok[ch] ? crc7_next(run_crc[ch], held[ch]) : run_crc[ch]};
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == sync_val || b == end_val);
        return b;
    endfunction

    // Queues up one frame, or a burst of line noise, for a channel. The kind
    // picks the shape: mostly good frames, then bad checks, short frames,
    // frames cut off by the next sync, noise and the occasional long frame.
    function automatic void plan_frame(input int ch, input int kind);
        int n;
        int i;
        if (kind >= 88 && kind < 96)
        begin
            repeat ($urandom_range(1, 4))
                frame_plan[ch].push_back(int'($urandom_range(0, 255)));
            return;
        end
        if (kind >= 100)
            n = 300;
        else if (kind >= 96)
            n = int'($urandom_range(66, 120));
        else if (kind >= 72 && kind < 80)
            n = int'($urandom_range(0, 1));
        else
            n = int'($urandom_range(1, 20));
        frame_plan[ch].push_back(int'(sync_val));
        i = 0;
        while (i < n)
        begin
            if ($urandom_range(0, 6) == 0 && esc_val != sync_val && esc_val != end_val)
            begin
                // An escape at the very end of the body is left dangling.
                frame_plan[ch].push_back(int'(esc_val));
                i++;
                if (i < n)
                begin
                    frame_plan[ch].push_back(int'(plain_byte()));
                    i++;
                end
            end
            else
            begin
                frame_plan[ch].push_back(int'(plain_byte()));
                i++;
            end
        end
        if (kind >= 80 && kind < 88)
            return;
        if (kind < 60 || kind >= 96)
            frame_plan[ch].push_back(CRC_SLOT);
        else if (kind < 72)
            frame_plan[ch].push_back(int'($urandom_range(0, 255)));
        frame_plan[ch].push_back(int'(end_val));
    endfunction

    function automatic stim_row_t mk_row(input logic [1:0] ch, input logic [7:0] b,
                                         input row_kind_t kind,
                                         input bsfd_pkg::status_t st = bsfd_pkg::STATUS_OK);
        stim_row_t r;
        r.channel = ch;
        r.rx_byte = b;
        r.kind    = kind;
        r.status  = st;
        return r;
    endfunction

    // Offers one item beat and returns at the edge that accepts it. The sender
    // works in bursts and pauses between them, except while the receiver is in
    // its long hold-off, when it keeps pushing so that the pipeline backs up.
    task automatic offer_beat(input bsfd_pkg::item_t beat);
        if (burst_left == 0 && !in_long_hold)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left != 0)
            burst_left--;
        item <= beat;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Drains the block: the sender goes quiet, every awaited result must come
    // back, and a few more cycles cover beats that produce nothing.
    task automatic settle();
        item_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers back to back; valid stays high between writes.
    task automatic apply_config(input bsfd_pkg::cfg_t c);
        bsfd_pkg::cfg_index_t idx;
        logic [7:0]           val;
        for (int i = 0; i < 4; i++)
        begin
            idx = bsfd_pkg::cfg_index_t'(i);
            case (idx)
                bsfd_pkg::CFG_SYNC:   val = c.sync_value;
                bsfd_pkg::CFG_END:    val = c.end_value;
                bsfd_pkg::CFG_ESCAPE: val = c.escape_value;
                default:              val = {4'h0, c.first_interface};
            endcase
            cfg_index <= idx;
            cfg_data <= val;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                bsfd_pkg::CFG_SYNC:   sync_val = val;
                bsfd_pkg::CFG_END:    end_val = val;
                bsfd_pkg::CFG_ESCAPE: esc_val = val;
                default:              first_if = val[3:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Random traffic until the given number of beats has landed inside frames
    // (bytes dropped while hunting do not count). Channels are picked at random
    // for every beat so that contexts interleave; channel zero, while a long frame
    // is under way on it, gets most of the picks so that the frame actually finishes.
    task automatic random_traffic(input int unsigned beats);
        int unsigned       done;
        int                ch;
        int                code;
        bsfd_pkg::item_t   beat;
        bsfd_pkg::result_t r;
        bit                counted;
        done = 0;
        while (done < beats)
        begin
            if (frame_plan[0].size() > 8 && $urandom_range(0, 3) != 0)
                ch = 0;
            else
                ch = int'($urandom_range(0, CHANNELS - 1));
            if (frame_plan[ch].size() == 0)
                plan_frame(ch, int'($urandom_range(0, 99)));
            code = frame_plan[ch].pop_front();
            beat.channel = 2'(ch);
            beat.rx_byte = (code == CRC_SLOT) ? crc_byte_for(ch) : code[7:0];
            offer_beat(beat);
            counted = in_frame[ch] || beat.rx_byte == sync_val;
            if (deframe_byte(beat, r))
                due_beats.push_back(r);
            if (counted)
                done++;
        end
    endtask

    // Receiver pacing: stretches of free flow, light stalling, heavy stalling
    // and alternate-cycle stalling. On request it holds off once for a long
    // stretch, counting the cycles itself.
    always
    begin : receiver_pacing
        int stretch;
        int mode;
        stretch = int'($urandom_range(10, 80));
        mode = int'($urandom_range(0, 3));
        repeat (stretch)
        begin
            @(posedge clk);
            if (long_hold_wanted)
            begin
                long_hold_wanted = 1'b0;
                in_long_hold = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                in_long_hold = 1'b0;
            end
            case (mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= ~result_stall;
            endcase
        end
    end

    // Every result beat taken is compared, field by field, with the oldest one
    // awaited. Signals are read straight after the edge, so they still hold the
    // values that the edge sampled.
    always @(posedge clk)
    begin : result_check
        bsfd_pkg::result_t want;
        if (result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (due_beats.size() == 0)
            begin
                $error({"result beat with nothing awaited: ",
                        "interface_id %0d frame_byte %0d last %0d status %0d"},
                       result.interface_id, result.frame_byte, result.last, result.status);
                mismatches++;
            end
            else
            begin
                want = due_beats.pop_front();
                if (result.interface_id !== want.interface_id)
                begin
                    $error("interface_id: expected %0d, got %0d",
                           want.interface_id, result.interface_id);
                    mismatches++;
                end
                if (result.frame_byte !== want.frame_byte)
                begin
                    $error("frame_byte: expected %0d, got %0d", want.frame_byte, result.frame_byte);
                    mismatches++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    mismatches++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        bsfd_pkg::item_t   beat;
        bsfd_pkg::result_t got;
        bsfd_pkg::result_t typed;
        bit                has;
        bsfd_pkg::cfg_t    wild;

        sync_val = bsfd_pkg::SYNC_RESET;
        end_val  = bsfd_pkg::END_RESET;
        esc_val  = bsfd_pkg::ESCAPE_RESET;
        first_if = bsfd_pkg::FIRST_IF_RESET;
        for (int ch = 0; ch < CHANNELS; ch++)
            clear_context(ch, 1'b0);

        // Directed frames under the reset register values (sync FE, end FF,
        // escape FD, channel zero is interface zero). Status rows carry their
        // result as typed; the rest are left to the predictor.
        rows.push_back(mk_row(2'd0, 8'h00, ROW_QUIET));               // hunting, ignored
        rows.push_back(mk_row(2'd0, 8'hFF, ROW_QUIET));               // stray end byte
        rows.push_back(mk_row(2'd0, 8'hFE, ROW_QUIET));
        rows.push_back(mk_row(2'd0, 8'hFF, ROW_STATUS, bsfd_pkg::STATUS_SHORT)); // empty frame
        rows.push_back(mk_row(2'd1, 8'hFE, ROW_QUIET));
        rows.push_back(mk_row(2'd1, 8'h41, ROW_QUIET));
        rows.push_back(mk_row(2'd1, 8'hFD, ROW_PREDICT));
        rows.push_back(mk_row(2'd1, 8'h02, ROW_PREDICT));             // escape held back
        rows.push_back(mk_row(2'd1, 8'h00, ROW_PREDICT));             // escaped byte comes out as FF
        rows.push_back(mk_row(2'd1, 8'h00, ROW_CRC));
        rows.push_back(mk_row(2'd1, 8'hFF, ROW_STATUS, bsfd_pkg::STATUS_OK));
        rows.push_back(mk_row(2'd2, 8'hFE, ROW_QUIET));
        rows.push_back(mk_row(2'd2, 8'h55, ROW_QUIET));
        rows.push_back(mk_row(2'd2, 8'hAA, ROW_PREDICT));             // check byte above 7 bits
        rows.push_back(mk_row(2'd2, 8'hFF, ROW_STATUS, bsfd_pkg::STATUS_CRC));
        rows.push_back(mk_row(2'd3, 8'hFE, ROW_QUIET));
        rows.push_back(mk_row(2'd3, 8'h01, ROW_QUIET));
        rows.push_back(mk_row(2'd3, 8'hFE, ROW_STATUS, bsfd_pkg::STATUS_RESTART));
        rows.push_back(mk_row(2'd3, 8'hFD, ROW_QUIET));
        rows.push_back(mk_row(2'd3, 8'h00, ROW_CRC));                 // dangling escape
        rows.push_back(mk_row(2'd3, 8'hFF, ROW_STATUS, bsfd_pkg::STATUS_OK));
        rows.push_back(mk_row(2'd0, 8'hFE, ROW_QUIET));
        rows.push_back(mk_row(2'd0, 8'h20, ROW_QUIET));
        rows.push_back(mk_row(2'd0, 8'hFD, ROW_PREDICT));
        // End straight after an escape.
        rows.push_back(mk_row(2'd0, 8'hFF, ROW_STATUS, bsfd_pkg::STATUS_CRC));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            beat.channel = rows[i].channel;
            beat.rx_byte = (rows[i].kind == ROW_CRC) ? crc_byte_for(rows[i].channel)
                                                     : rows[i].rx_byte;
            offer_beat(beat);
            has = deframe_byte(beat, got);
            if (rows[i].kind == ROW_STATUS)
            begin
                typed.interface_id = {3'b000, rows[i].channel};
                typed.frame_byte   = 8'h00;
                typed.last         = 1'b1;
                typed.status       = rows[i].status;
                due_beats.push_back(typed);
            end
            else if (rows[i].kind != ROW_QUIET && has)
                due_beats.push_back(got);
        end

        // First random phase under the reset values. Channel zero is given a
        // frame long enough to overflow and then one past the data limit, and
        // the receiver is asked for its long hold-off early on.
        plan_frame(0, 100);
        plan_frame(0, 96);
        long_hold_wanted = 1'b1;
        random_traffic(500);

        // Further phases at the register extremes, with sync equal to end in
        // one of them, and a last phase with drawn values.
        for (int p = 0; p < 4; p++)
        begin
            settle();
            if (p < 3)
                apply_config(PHASE_CFG[p]);
            else
            begin
                wild.sync_value      = 8'($urandom_range(0, 255));
                wild.end_value       = 8'($urandom_range(0, 255));
                wild.escape_value    = 8'($urandom_range(0, 255));
                wild.first_interface = 4'($urandom_range(0, 15));
                apply_config(wild);
            end
            @(posedge clk);
            random_traffic(130);
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
